/* rtl/real_spherical_harmonic_eval_assert.svh */
// Assertion macros for the spherical-harmonic evaluator.
// Used by the port checker; needs no other file.
`ifndef REAL_SPHERICAL_HARMONIC_EVAL_ASSERT_SVH
`define REAL_SPHERICAL_HARMONIC_EVAL_ASSERT_SVH
// same-cycle implication under reset
`define RSHE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under reset
`define RSHE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/rshe_pkg.sv */
// Shared types, constants and the normalisation table of the evaluator.
// No dependencies.
package rshe_pkg;

    localparam int MAX_BAND = 6;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [95:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [4:0]  den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    // entry: {exponent[5:0], mantissa[31:0]}, index {l, |m|, m != 0}
    typedef logic [127:0][37:0] k_tab_t;

    function automatic logic [63:0] fact(input int n);
        logic [63:0] f;
        int          j;
        f = 64'd1;
        if ((n & 15) <= 12) begin
            for (j = 2; j <= (n & 15); j++) begin
                f = f * 64'(j);
            end
        end
        return f;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        int          j;
        v    = v_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic k_tab_t build_k_tab();
        k_tab_t      t;
        int          idx;
        int          l;
        int          am;
        int          k;
        int          j;
        int          e;
        logic [63:0] x;
        logic [63:0] d;
        logic [63:0] rem;
        logic [63:0] q;
        logic [63:0] kq;
        for (idx = 0; idx < 128; idx++) begin
            l  = (idx >> 4) & 7;
            am = (idx >> 1) & 7;
            x  = 64'(2 * l + 1) * fact(l - am);
            d  = PI_Q30 * fact(l + am);
            if ((idx & 1) != 0) begin
                x = x * 64'd2;
            end
            rem = x;
            q   = 64'd0;
            k   = 0;
            while (q < (64'd1 << 60) && k < 200) begin
                for (j = 0; j < 2; j++) begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= d) begin
                        rem = rem - d;
                        q   = q | 64'd1;
                    end
                end
                k += 2;
            end
            e = (k - 28) / 2;
            if (e < 30) e = 30;
            if (e > 62) e = 62;
            kq = isqrt64(q);
            t[idx] = {6'(e), kq[31:0]};
        end
        return t;
    endfunction

    localparam k_tab_t K_TAB = build_k_tab();

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

/* rtl/rshe_mul.sv */
// Shared 64x32 multiplier, two passes through one 32x32 product.
// Depends on rshe_pkg.
module rshe_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  rshe_pkg::mul_req_t req,
    output rshe_pkg::mul_rsp_t rsp
);
    import rshe_pkg::*;

    logic [63:0] a_reg;
    logic [31:0] b_reg;
    logic [95:0] acc_reg;
    logic [1:0]  phase_reg;
    logic        done_reg;
    logic [63:0] part;

    assign part = (phase_reg == 2'd1) ? a_reg[31:0] * b_reg : a_reg[63:32] * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                2'd1:    phase_reg <= 2'd2;
                2'd2:
                begin
                    phase_reg <= 2'd0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    if (req.start)
                    begin
                        phase_reg <= 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == 2'd0 && req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        if (phase_reg == 2'd1)
        begin
            acc_reg <= {32'd0, part};
        end
        else if (phase_reg == 2'd2)
        begin
            acc_reg <= acc_reg + {part, 32'd0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

/* rtl/rshe_div.sv */
// Restoring divider, one quotient bit a cycle, small divisor.
// Depends on rshe_pkg.
module rshe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rshe_pkg::div_req_t req,
    output rshe_pkg::div_rsp_t rsp
);
    import rshe_pkg::*;

    logic [63:0] quo_reg;
    logic [4:0]  rem_reg;
    logic [4:0]  den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  rem_sh;
    logic        fits;
    logic [5:0]  rem_sub;

    assign rem_sh  = {rem_reg, quo_reg[63]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            quo_reg <= {quo_reg[62:0], fits};
            rem_reg <= fits ? rem_sub[4:0] : rem_sh[4:0];
        end
        else if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= 5'd0;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/real_spherical_harmonic_eval.sv */
// Real spherical-harmonic basis evaluator, Legendre recurrence on shared units.
// The recurrence steps and, for m != 0, the 16 Taylor steps through the shared divider
// set most of the run time. A new word is taken only in the idle state, once the last
// result is loaded for output; an out-of-range band or order skips all arithmetic.
// Reset clears control state only. Depends on rshe_pkg, rshe_mul, rshe_div.
module real_spherical_harmonic_eval (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         band,
    input  logic signed [3:0]  order,
    input  logic signed [31:0] cos_polar,
    input  logic [31:0]        azimuth,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] basis_value,
    output logic               status
);
    import rshe_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SQ_MUL  = 5'd1;
    localparam logic [4:0] ST_SQ_W    = 5'd2;
    localparam logic [4:0] ST_SQRT    = 5'd3;
    localparam logic [4:0] ST_PMM_MUL = 5'd4;
    localparam logic [4:0] ST_PMM_W   = 5'd5;
    localparam logic [4:0] ST_PMM_K   = 5'd6;
    localparam logic [4:0] ST_PMM_KW  = 5'd7;
    localparam logic [4:0] ST_LEG1    = 5'd8;
    localparam logic [4:0] ST_L1_W    = 5'd9;
    localparam logic [4:0] ST_L1_K    = 5'd10;
    localparam logic [4:0] ST_L1_KW   = 5'd11;
    localparam logic [4:0] ST_REC_MUL = 5'd12;
    localparam logic [4:0] ST_REC_W   = 5'd13;
    localparam logic [4:0] ST_REC_K   = 5'd14;
    localparam logic [4:0] ST_REC_KW  = 5'd15;
    localparam logic [4:0] ST_REC_K2  = 5'd16;
    localparam logic [4:0] ST_REC_K2W = 5'd17;
    localparam logic [4:0] ST_REC_DIV = 5'd18;
    localparam logic [4:0] ST_NORM    = 5'd19;
    localparam logic [4:0] ST_NORM_W  = 5'd20;
    localparam logic [4:0] ST_ANG     = 5'd21;
    localparam logic [4:0] ST_ANG_W   = 5'd22;
    localparam logic [4:0] ST_TH      = 5'd23;
    localparam logic [4:0] ST_TH_W    = 5'd24;
    localparam logic [4:0] ST_TAY_MUL = 5'd25;
    localparam logic [4:0] ST_TAY_W   = 5'd26;
    localparam logic [4:0] ST_TAY_DIV = 5'd27;
    localparam logic [4:0] ST_TRIG    = 5'd28;
    localparam logic [4:0] ST_TRIG_W  = 5'd29;
    localparam logic [4:0] ST_FIN     = 5'd30;

    logic [4:0]         state_reg, state_next;
    logic [2:0]         l_reg, l_next;
    logic [2:0]         am_reg, am_next;
    logic               fold_reg, fold_next;
    logic               mpos_reg, mpos_next;
    logic signed [31:0] x_reg, x_next;
    logic [31:0]        az_reg, az_next;
    logic [4:0]         i_reg, i_next;
    logic [31:0]        s_reg, s_next;
    logic signed [63:0] pmm_reg, pmm_next;
    logic signed [63:0] pmmp1_reg, pmmp1_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic               sgn_reg, sgn_next;
    logic               neg_reg, neg_next;
    logic               stat_reg, stat_next;
    logic [63:0]        v_reg, v_next;
    logic [63:0]        res_reg, res_next;
    logic [31:0]        ang_reg, ang_next;
    logic [31:0]        th_reg, th_next;
    logic signed [39:0] sacc_reg, sacc_next;
    logic signed [39:0] cacc_reg, cacc_next;
    logic [34:0]        kp_reg, kp_next;
    logic [63:0]        mag_reg, mag_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] basis_reg, basis_next;
    logic               status_reg, status_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [3:0]         am_in;
    logic [37:0]        k_ent;
    logic [5:0]         k_exp;
    logic [63:0]        sq_bit;
    logic [95:0]        rnd30;
    logic [95:0]        kp_sum;
    logic [95:0]        kp_sh;
    logic [95:0]        tay_sum;
    logic [63:0]        tay_num;
    logic signed [63:0] prod_s;
    logic signed [63:0] num_s;
    logic [4:0]         rec_den;
    logic [30:0]        s_cl;
    logic [30:0]        c_cl;
    logic [30:0]        t_mag;
    logic               t_neg;
    logic [32:0]        mag_cl;
    logic [95:0]        trig_sum;
    logic [95:0]        th_sum;

    rshe_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    rshe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign am_in    = order[3] ? 4'(-order) : 4'(order);
    assign k_ent    = K_TAB[{l_reg, am_reg, fold_reg}];
    assign k_exp    = k_ent[37:32];
    assign sq_bit   = 64'd1 << (7'd62 - {1'b0, i_reg, 1'b0});
    assign rnd30    = mrsp.prod + (96'd1 << 29);
    assign kp_sum   = mrsp.prod + (96'd1 << (k_exp - 6'd1));
    assign kp_sh    = kp_sum >> k_exp;
    assign tay_sum  = mrsp.prod + (96'd1 << 29);
    assign tay_num  = tay_sum[93:30] + 64'(i_reg >> 1);
    assign prod_s   = $signed(mrsp.prod[63:0]);
    assign num_s    = acc_reg - (pmm_reg[63] ? -prod_s : prod_s);
    assign rec_den  = i_reg - {2'b00, am_reg};
    assign trig_sum = mrsp.prod + (96'd1 << 31);
    assign th_sum   = mrsp.prod + (96'd1 << 30);
    assign mag_cl   = neg_reg ? ((mag_reg > 64'h8000_0000) ? 33'h0_8000_0000 : mag_reg[32:0])
                              : ((mag_reg > 64'h7FFF_FFFF) ? 33'h0_7FFF_FFFF : mag_reg[32:0]);

    always_comb
    begin
        s_cl = sacc_reg[39] ? 31'd0 : ((sacc_reg > 40'sd1073741824) ? 31'd1073741824
                                                                    : sacc_reg[30:0]);
        c_cl = cacc_reg[39] ? 31'd0 : ((cacc_reg > 40'sd1073741824) ? 31'd1073741824
                                                                    : cacc_reg[30:0]);
        if (mpos_reg)
        begin
            t_mag = ang_reg[30] ? s_cl : c_cl;
            t_neg = ang_reg[31] ^ ang_reg[30];
        end
        else
        begin
            t_mag = ang_reg[30] ? c_cl : s_cl;
            t_neg = ang_reg[31];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        l_next         = l_reg;
        am_next        = am_reg;
        fold_next      = fold_reg;
        mpos_next      = mpos_reg;
        x_next         = x_reg;
        az_next        = az_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        pmm_next       = pmm_reg;
        pmmp1_next     = pmmp1_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        sgn_next       = sgn_reg;
        neg_next       = neg_reg;
        stat_next      = stat_reg;
        v_next         = v_reg;
        res_next       = res_reg;
        ang_next       = ang_reg;
        th_next        = th_reg;
        sacc_next      = sacc_reg;
        cacc_next      = cacc_reg;
        kp_next        = kp_reg;
        mag_next       = mag_reg;
        basis_next     = basis_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mreq           = '0;
        dreq           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    l_next    = band;
                    am_next   = am_in[2:0];
                    fold_next = order != 4'sd0;
                    mpos_next = !order[3];
                    az_next   = azimuth;
                    pmm_next  = 64'sd1073741824;
                    if (cos_polar > Q30_ONE)
                    begin
                        x_next = Q30_ONE;
                    end
                    else if (cos_polar < -Q30_ONE)
                    begin
                        x_next = -Q30_ONE;
                    end
                    else
                    begin
                        x_next = cos_polar;
                    end
                    if ({1'b0, band} > 4'(MAX_BAND) || am_in > {1'b0, band})
                    begin
                        mag_next   = 64'd0;
                        neg_next   = 1'b0;
                        stat_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        stat_next  = 1'b0;
                        state_next = (am_in != 4'd0) ? ST_SQ_MUL : ST_LEG1;
                    end
                end
            end
            ST_SQ_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = {32'd0, 32'(Q30_ONE - x_reg)};
                mreq.b     = 32'(Q30_ONE + x_reg);
                state_next = ST_SQ_W;
            end
            ST_SQ_W:
            begin
                if (mrsp.done)
                begin
                    v_next     = mrsp.prod[63:0];
                    res_next   = 64'd0;
                    i_next     = 5'd0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (v_reg >= res_reg + sq_bit)
                begin
                    v_next   = v_reg - (res_reg + sq_bit);
                    res_next = (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'd31)
                begin
                    s_next     = res_next[31:0];
                    i_next     = 5'd1;
                    state_next = ST_PMM_MUL;
                end
            end
            ST_PMM_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = mag64(pmm_reg);
                mreq.b     = s_reg;
                state_next = ST_PMM_W;
            end
            ST_PMM_W:
            begin
                if (mrsp.done)
                begin
                    tmp_next   = rnd30[93:30];
                    state_next = ST_PMM_K;
                end
            end
            ST_PMM_K:
            begin
                mreq.start = 1'b1;
                mreq.a     = tmp_reg;
                mreq.b     = 32'({i_reg, 1'b0} - 6'd1);
                state_next = ST_PMM_KW;
            end
            ST_PMM_KW:
            begin
                if (mrsp.done)
                begin
                    pmm_next = pmm_reg[63] ? prod_s : -prod_s;
                    if (i_reg == {2'b00, am_reg})
                    begin
                        state_next = ST_LEG1;
                    end
                    else
                    begin
                        i_next     = i_reg + 5'd1;
                        state_next = ST_PMM_MUL;
                    end
                end
            end
            ST_LEG1:
            begin
                if (l_reg == am_reg)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    sgn_next   = pmm_reg[63] ^ x_reg[31];
                    mreq.start = 1'b1;
                    mreq.a     = mag64(pmm_reg);
                    mreq.b     = 32'(mag64(64'(x_reg)));
                    state_next = ST_L1_W;
                end
            end
            ST_L1_W:
            begin
                if (mrsp.done)
                begin
                    tmp_next   = rnd30[93:30];
                    state_next = ST_L1_K;
                end
            end
            ST_L1_K:
            begin
                mreq.start = 1'b1;
                mreq.a     = tmp_reg;
                mreq.b     = 32'({am_reg, 1'b1});
                state_next = ST_L1_KW;
            end
            ST_L1_KW:
            begin
                if (mrsp.done)
                begin
                    if ({1'b0, l_reg} == {1'b0, am_reg} + 4'd1)
                    begin
                        pmm_next   = sgn_reg ? -prod_s : prod_s;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        pmmp1_next = sgn_reg ? -prod_s : prod_s;
                        i_next     = {2'b00, am_reg} + 5'd2;
                        state_next = ST_REC_MUL;
                    end
                end
            end
            ST_REC_MUL:
            begin
                sgn_next   = pmmp1_reg[63] ^ x_reg[31];
                mreq.start = 1'b1;
                mreq.a     = mag64(pmmp1_reg);
                mreq.b     = 32'(mag64(64'(x_reg)));
                state_next = ST_REC_W;
            end
            ST_REC_W:
            begin
                if (mrsp.done)
                begin
                    tmp_next   = rnd30[93:30];
                    state_next = ST_REC_K;
                end
            end
            ST_REC_K:
            begin
                mreq.start = 1'b1;
                mreq.a     = tmp_reg;
                mreq.b     = 32'({i_reg, 1'b0} - 6'd1);
                state_next = ST_REC_KW;
            end
            ST_REC_KW:
            begin
                if (mrsp.done)
                begin
                    acc_next   = sgn_reg ? -prod_s : prod_s;
                    state_next = ST_REC_K2;
                end
            end
            ST_REC_K2:
            begin
                mreq.start = 1'b1;
                mreq.a     = mag64(pmm_reg);
                mreq.b     = 32'(i_reg + {2'b00, am_reg} - 5'd1);
                state_next = ST_REC_K2W;
            end
            ST_REC_K2W:
            begin
                if (mrsp.done)
                begin
                    sgn_next   = num_s[63];
                    dreq.start = 1'b1;
                    dreq.num   = mag64(num_s) + 64'(rec_den >> 1);
                    dreq.den   = rec_den;
                    state_next = ST_REC_DIV;
                end
            end
            ST_REC_DIV:
            begin
                if (drsp.done)
                begin
                    if (i_reg == {2'b00, l_reg})
                    begin
                        pmm_next   = sgn_reg ? -$signed(drsp.quo) : $signed(drsp.quo);
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        pmm_next   = pmmp1_reg;
                        pmmp1_next = sgn_reg ? -$signed(drsp.quo) : $signed(drsp.quo);
                        i_next     = i_reg + 5'd1;
                        state_next = ST_REC_MUL;
                    end
                end
            end
            ST_NORM:
            begin
                neg_next   = pmm_reg[63];
                mreq.start = 1'b1;
                mreq.a     = mag64(pmm_reg);
                mreq.b     = k_ent[31:0];
                state_next = ST_NORM_W;
            end
            ST_NORM_W:
            begin
                if (mrsp.done)
                begin
                    kp_next = (kp_sh > 96'h4_0000_0000) ? 35'h4_0000_0000 : kp_sh[34:0];
                    if (!fold_reg)
                    begin
                        mag_next   = 64'((kp_next + 35'd2) >> 2);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_ANG;
                    end
                end
            end
            ST_ANG:
            begin
                mreq.start = 1'b1;
                mreq.a     = {32'd0, az_reg};
                mreq.b     = {29'd0, am_reg};
                state_next = ST_ANG_W;
            end
            ST_ANG_W:
            begin
                if (mrsp.done)
                begin
                    ang_next   = mrsp.prod[31:0];
                    state_next = ST_TH;
                end
            end
            ST_TH:
            begin
                mreq.start = 1'b1;
                mreq.a     = {34'd0, ang_reg[29:0]};
                mreq.b     = PI_Q30[31:0];
                state_next = ST_TH_W;
            end
            ST_TH_W:
            begin
                if (mrsp.done)
                begin
                    th_next    = th_sum[62:31];
                    tmp_next   = 64'd1073741824;
                    sacc_next  = 40'sd0;
                    cacc_next  = 40'sd1073741824;
                    i_next     = 5'd1;
                    state_next = ST_TAY_MUL;
                end
            end
            ST_TAY_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = tmp_reg;
                mreq.b     = th_reg;
                state_next = ST_TAY_W;
            end
            ST_TAY_W:
            begin
                if (mrsp.done)
                begin
                    dreq.start = 1'b1;
                    dreq.num   = tay_num;
                    dreq.den   = i_reg;
                    state_next = ST_TAY_DIV;
                end
            end
            ST_TAY_DIV:
            begin
                if (drsp.done)
                begin
                    tmp_next = drsp.quo;
                    unique case (i_reg[1:0])
                        2'd1:    sacc_next = sacc_reg + $signed({6'd0, drsp.quo[33:0]});
                        2'd2:    cacc_next = cacc_reg - $signed({6'd0, drsp.quo[33:0]});
                        2'd3:    sacc_next = sacc_reg - $signed({6'd0, drsp.quo[33:0]});
                        default: cacc_next = cacc_reg + $signed({6'd0, drsp.quo[33:0]});
                    endcase
                    if (i_reg == 5'd16)
                    begin
                        state_next = ST_TRIG;
                    end
                    else
                    begin
                        i_next     = i_reg + 5'd1;
                        state_next = ST_TAY_MUL;
                    end
                end
            end
            ST_TRIG:
            begin
                neg_next   = neg_reg ^ (t_neg && t_mag != 31'd0);
                mreq.start = 1'b1;
                mreq.a     = {29'd0, kp_reg};
                mreq.b     = {1'b0, t_mag};
                state_next = ST_TRIG_W;
            end
            ST_TRIG_W:
            begin
                if (mrsp.done)
                begin
                    mag_next   = trig_sum[95:32];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    basis_next     = neg_reg ? 32'(-mag_cl) : 32'(mag_cl);
                    status_next    = stat_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg      <= l_next;
        am_reg     <= am_next;
        fold_reg   <= fold_next;
        mpos_reg   <= mpos_next;
        x_reg      <= x_next;
        az_reg     <= az_next;
        i_reg      <= i_next;
        s_reg      <= s_next;
        pmm_reg    <= pmm_next;
        pmmp1_reg  <= pmmp1_next;
        acc_reg    <= acc_next;
        tmp_reg    <= tmp_next;
        sgn_reg    <= sgn_next;
        neg_reg    <= neg_next;
        stat_reg   <= stat_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        ang_reg    <= ang_next;
        th_reg     <= th_next;
        sacc_reg   <= sacc_next;
        cacc_reg   <= cacc_next;
        kp_reg     <= kp_next;
        mag_reg    <= mag_next;
        basis_reg  <= basis_next;
        status_reg <= status_next;
    end

    assign in_ready    = state_reg == ST_IDLE;
    assign out_valid   = out_valid_reg;
    assign basis_value = basis_reg;
    assign status      = status_reg;

endmodule

/* rtl/rshe_checker.sv */
// Port-level checks on the evaluator, bound to the top level.
// Depends on real_spherical_harmonic_eval_assert.svh.
`include "real_spherical_harmonic_eval_assert.svh"
module rshe_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] basis_value,
    input logic               status
);
    `RSHE_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && status, basis_value == 32'sd0, "invalid word carries a non-zero value")
    `RSHE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "input taken again before the word finished")
    `RSHE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(basis_value) && $stable(status), "stalled result word changed")
endmodule

bind real_spherical_harmonic_eval rshe_checker u_rshe_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .basis_value(basis_value),
    .status(status)
);

/* tb/testbench.sv */
// Self-checking testbench for the spherical-harmonic basis evaluator.
// Holds a bit-exact predictor, a small scoreboard class and handshake drivers;
// depends on rshe_pkg and the evaluator RTL.
module testbench;
    import rshe_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam longint ONE_Q30 = 64'sd1073741824;

    typedef struct {
        logic [31:0] value;
        logic        invalid;
    } sh_word_t;

    class basis_scoreboard;
        sh_word_t pending[$];
        int       errors;
        int       checked;

        function void note_input(sh_word_t w);
            pending.push_back(w);
        endfunction

        function void check_result(logic [31:0] value, logic invalid);
            sh_word_t w;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing pending");
                return;
            end
            w = pending.pop_front();
            checked++;
            if (value !== w.value)
                report_mismatch($sformatf("basis_value got %h want %h", value, w.value));
            if (invalid !== w.invalid)
                report_mismatch($sformatf("status got %b want %b", invalid, w.invalid));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t: %s", $time, msg);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         band;
    logic signed [3:0]  order;
    logic signed [31:0] cos_polar;
    logic [31:0]        azimuth;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] basis_value;
    logic               status;

    basis_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  sent;
    int  quiet_cycles;
    bit  timed_out;

    real_spherical_harmonic_eval dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .band(band), .order(order), .cos_polar(cos_polar), .azimuth(azimuth),
        .out_valid(out_valid), .out_ready(out_ready),
        .basis_value(basis_value), .status(status)
    );

    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint with_sign(longint unsigned mg, bit neg);
        return neg ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint scale_q30(longint a, longint x);
        longint unsigned ua;
        longint unsigned ux;
        longint unsigned r;
        ua = mag_of(a);
        ux = mag_of(x);
        r = (ua >> 30) * ux + (((ua & 64'h3FFF_FFFF) * ux + (64'd1 << 29)) >> 30);
        return with_sign(r, (a < 0) != (x < 0));
    endfunction

    function automatic longint legendre_q30(int l, int m, longint x);
        longint pmm;
        longint pnext;
        longint pll;
        longint s;
        longint num;
        longint unsigned un;
        pmm = ONE_Q30;
        pll = 0;
        if (m > 0)
        begin
            s = longint'(sqrt_floor(longint'(ONE_Q30 - x) * longint'(ONE_Q30 + x)));
            for (int i = 1; i <= m; i++) pmm = -longint'(2 * i - 1) * scale_q30(pmm, s);
        end
        if (l == m) return pmm;
        pnext = longint'(2 * m + 1) * scale_q30(pmm, x);
        if (l == m + 1) return pnext;
        for (int i = m + 2; i <= l; i++)
        begin
            num = longint'(2 * i - 1) * scale_q30(pnext, x) - longint'(i + m - 1) * pmm;
            un = mag_of(num);
            pll = with_sign((un + (i - m) / 2) / longint'(i - m), num < 0);
            pmm = pnext;
            pnext = pll;
        end
        return pll;
    endfunction

    function automatic longint unsigned factorial(int n);
        longint unsigned f;
        f = 1;
        for (int j = 2; j <= n; j++) f *= j;
        return f;
    endfunction

    function automatic longint unsigned norm_mantissa(int l, int am, bit fold, output int e);
        longint unsigned x;
        longint unsigned d;
        longint unsigned rem;
        longint unsigned q;
        int k;
        x = longint'(2 * l + 1) * factorial(l - am);
        d = 64'd3373259426 * factorial(l + am);
        if (fold) x *= 2;
        rem = x;
        q = 0;
        k = 0;
        while (q < (64'd1 << 60) && k < 200)
        begin
            for (int j = 0; j < 2; j++)
            begin
                rem <<= 1;
                q <<= 1;
                if (rem >= d)
                begin
                    rem -= d;
                    q |= 1;
                end
            end
            k += 2;
        end
        e = (k - 28) / 2;
        if (e < 30) e = 30;
        if (e > 62) e = 62;
        return sqrt_floor(q);
    endfunction

    function automatic void turn_sincos(logic [31:0] a, output longint sv, output longint cv);
        longint unsigned r;
        longint unsigned th;
        longint unsigned term;
        longint s;
        longint c;
        r = a[29:0];
        th = (r * 64'd3373259426 + (64'd1 << 30)) >> 31;
        term = ONE_Q30;
        s = 0;
        c = ONE_Q30;
        for (int n = 1; n <= 16; n++)
        begin
            term = (((term * th + (64'd1 << 29)) >> 30) + longint'(n / 2)) / longint'(n);
            case (n & 3)
                1: s += term;
                2: c -= term;
                3: s -= term;
                default: c += term;
            endcase
        end
        if (s < 0) s = 0;
        if (s > ONE_Q30) s = ONE_Q30;
        if (c < 0) c = 0;
        if (c > ONE_Q30) c = ONE_Q30;
        case (a[31:30])
            2'd0: begin sv = s; cv = c; end
            2'd1: begin sv = c; cv = -s; end
            2'd2: begin sv = -s; cv = -c; end
            default: begin sv = -c; cv = s; end
        endcase
    endfunction

    function automatic sh_word_t predict_basis(logic [2:0] l_in, logic signed [3:0] m_in,
                                               logic signed [31:0] cp, logic [31:0] az);
        sh_word_t w;
        int l;
        int m;
        int am;
        int e;
        longint x;
        longint p;
        longint sv;
        longint cv;
        longint t;
        longint unsigned kq;
        longint unsigned up;
        longint unsigned b;
        longint unsigned kp;
        longint unsigned mg;
        bit neg;
        logic [31:0] ang;
        l = l_in;
        m = m_in;
        am = m < 0 ? -m : m;
        w.value = '0;
        w.invalid = 1'b1;
        if (l > MAX_BAND || am > l) return w;
        x = cp;
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        p = legendre_q30(l, am, x);
        kq = norm_mantissa(l, am, m != 0, e);
        up = mag_of(p);
        b = kq * (up & 64'h3FFF_FFFF) + (64'd1 << ((e - 1) & 63));
        kp = (kq * (up >> 30) + (b >> 30)) >> ((e - 30) & 63);
        if (kp > (64'd1 << 34)) kp = 64'd1 << 34;
        neg = p < 0;
        if (m == 0)
            mg = (kp + 2) >> 2;
        else
        begin
            ang = 32'(am) * az;
            turn_sincos(ang, sv, cv);
            t = m > 0 ? cv : sv;
            mg = (kp * mag_of(t) + (64'd1 << 31)) >> 32;
            if (t < 0) neg = !neg;
        end
        if (neg)
        begin
            if (mg > 64'h8000_0000) mg = 64'h8000_0000;
            w.value = 32'(longint'(0) - longint'(mg));
        end
        else
        begin
            if (mg > 64'h7FFF_FFFF) mg = 64'h7FFF_FFFF;
            w.value = mg[31:0];
        end
        w.invalid = 1'b0;
        return w;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(int l, int m, logic [31:0] cp, logic [31:0] az);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        band      <= 3'(l);
        order     <= 4'(m);
        cos_polar <= cp;
        azimuth   <= az;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(predict_basis(3'(l), 4'(m), cp, az));
        sent++;
    endtask

    task automatic send_random(int count);
        int l;
        int m;
        logic [31:0] cp;
        for (int i = 0; i < count; i++)
        begin
            l = $urandom_range(99) < 90 ? $urandom_range(MAX_BAND) : $urandom_range(7);
            m = $urandom_range(99) < 85 ? int'($urandom_range(2 * l)) - l
                                        : int'($urandom_range(15)) - 8;
            case ($urandom_range(9))
                0: cp = $urandom;
                1: cp = $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
                default: cp = 32'(int'($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
            endcase
            send_word(l, m, cp, $urandom);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) sb.check_result(basis_value, status);
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                timed_out = 1'b1;
                $display("watchdog expired with %0d words pending", sb.pending.size());
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        band = '0;
        order = '0;
        cos_polar = '0;
        azimuth = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(0, 0, 32'h4000_0000, 0);
        send_word(6, 0, 32'hC000_0000, 0);
        send_word(6, 6, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(6, -6, 32'h2000_0000, 32'h4000_0000);
        send_word(5, 3, 32'h7FFF_FFFF, 32'h1234_5678);
        send_word(5, -3, 32'h8000_0000, 32'h8000_0000);
        send_word(3, 1, 32'h5A82_7999, 32'hC000_0000);
        send_word(3, -2, 32'hA57D_8667, 32'h2000_0000);
        send_word(7, 0, 32'h0, 0);
        send_word(2, 3, 32'h0, 0);
        send_word(6, -8, 32'h0, 0);
        send_word(0, -1, 32'h0, 0);
        send_word(1, 1, 32'h4000_0000, 32'h0);
        send_word(4, -4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(2, 0, 32'h3FFF_FFFF, 32'hAAAA_5555);
        drain();

        send_random(150);
        send_idle_pct = 87;
        send_random(130);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        send_random(130);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        send_random(100);
        recv_stall_pct = 0;
        send_idle_pct = 0;

        fork
            begin
                hold_off = 1'b1;
                repeat (6000) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(40);
        join
        send_random(90);

        drain();
        repeat (3000) @(posedge clk);
        $display("run covered %0d words, %0d results checked across idle and stall phases",
                 sent, sb.checked);
        $display("bands 0..7 with in-range, out-of-range and -8 orders; cosine clamping");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
